// ===== hdl/bytecode_instruction_decoder_core_assert.svh =====
// Assertion macros used by the decoder checker file.
// No dependencies; take in with `include before use.
`ifndef BYTECODE_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define BYTECODE_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BID_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bid_pkg.sv =====
// Types and constants for the bytecode instruction decoder.
// No dependencies; used by the core and its checker.
`default_nettype none

package bid_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] REG_FUNCTION_BASE   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FUNCTION_LENGTH = 8'd1;

   // code-target opcodes: jump, conditional jump, loop, push handler
   localparam logic [7:0] OP_JUMP         = 8'd28;
   localparam logic [7:0] OP_JUMP_COND    = 8'd29;
   localparam logic [7:0] OP_LOOP         = 8'd30;
   localparam logic [7:0] OP_PUSH_HANDLER = 8'd57;

   localparam logic [3:0] LAST_VARINT_BYTE = 4'd9;
   localparam logic [3:0] LAST_SHIFT_SLOT  = 4'd4;

   function automatic logic is_code_target(input logic [7:0] op);
      return (op == OP_JUMP) || (op == OP_JUMP_COND) ||
             (op == OP_LOOP) || (op == OP_PUSH_HANDLER);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bytecode_instruction_decoder_core.sv =====
// Byte-serial decoder for one function body: opcode byte plus zigzag LEB128 operand.
// Depends on bid_pkg.
`default_nettype none

// Usage:
//   req_*  : one stream byte per word in req_tdata[7:0].
//   rsp_*  : one word per decoded instruction, issued on the byte that ends
//            its operand varint. tdata = opcode, operand, instr_index;
//            tlast = last instruction of the body; tuser = status.
//   csr_*  : register writes (0 function_base, 1 function_length). Any write
//            to a known register restarts decoding at the first instruction.
//   Throughput is one byte per cycle while req_tready is high; the decode of a
//   byte is done in the cycle it is accepted and the result is in the output
//   register on the next cycle.
//   req_tready drops only while a result waits in the output register and
//   rsp_tready is low; the output register is the only stall point.
//   After a status error or once function_length instructions are out,
//   bytes are taken and dropped until the next write to a known register.
//   Reset (synchronous) clears the decoder and sets base 0, length 1.
module bytecode_instruction_decoder_core #(
   parameter int MAX_CODE = 65536
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // req_tdata: [7:0] byte_in
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [bid_pkg::REQ_DATA_W-1:0]        req_tdata,
   // rsp_tdata: [7:0] opcode_out, [39:8] operand_out, [55:40] instr_index
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [bid_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast,
   // rsp_tuser: [1:0] status
   output logic [bid_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [bid_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [bid_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bid_pkg::*;

   localparam int CapBits = $clog2(MAX_CODE + 1);
   localparam int CapW = (CapBits > CSR_DATA_W) ? CapBits : CSR_DATA_W;
   localparam logic [CapW-1:0] Cap = CapW'(MAX_CODE);

   logic [15:0]  base_ff;
   logic [16:0]  length_ff;
   logic         in_operand_ff;
   logic [7:0]   opcode_ff;
   logic [32:0]  accum_ff;
   logic [3:0]   shift_ff;
   logic [16:0]  count_ff;
   logic         halted_ff;

   logic         rsp_valid_ff;
   logic [7:0]   rsp_opcode_ff;
   logic [31:0]  rsp_operand_ff;
   logic [15:0]  rsp_index_ff;
   logic         rsp_last_ff;
   status_type   rsp_status_ff;

   logic         accept;
   logic         active;
   logic         cfg_hit;
   logic [16:0]  length_in;
   logic [6:0]   payload;
   logic [39:0]  shifted;
   logic [39:0]  merged;
   logic [32:0]  accum_in;
   logic         done;
   logic         emit;
   logic [31:0]  zig;
   logic [31:0]  operand;
   logic         out_of_range;
   logic [31:0]  operand_in;
   status_type   status_in;
   logic [16:0]  count_inc;
   logic [15:0]  index_in;
   logic         last_in;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign active     = !halted_ff && (count_ff < length_ff);
   assign cfg_hit    = csr_valid &&
                       (csr_index == REG_FUNCTION_BASE || csr_index == REG_FUNCTION_LENGTH);

   assign length_in = (CapW'(csr_wdata) > Cap) ? CSR_DATA_W'(Cap) : csr_wdata;

   assign payload = req_tdata[6:0];

   always_comb begin
      unique case (shift_ff)
         4'd0:    shifted = {33'b0, payload};
         4'd1:    shifted = {26'b0, payload, 7'b0};
         4'd2:    shifted = {19'b0, payload, 14'b0};
         4'd3:    shifted = {12'b0, payload, 21'b0};
         4'd4:    shifted = {5'b0, payload, 28'b0};
         default: shifted = '0;
      endcase
   end

   assign merged = {7'b0, accum_ff} | shifted;

   // bit 32 is a sticky overflow mark; bytes past the fifth may only add zeros
   always_comb begin
      if (shift_ff <= LAST_SHIFT_SLOT) begin
         accum_in = {|merged[39:32], merged[31:0]};
      end else begin
         accum_in = {accum_ff[32] | (payload != 7'd0), accum_ff[31:0]};
      end
   end

   assign done = !req_tdata[7] || (shift_ff == LAST_VARINT_BYTE);
   assign emit = accept && active && in_operand_ff && done;

   assign zig          = accum_in[31:0];
   assign operand      = {1'b0, zig[31:1]} ^ {32{zig[0]}};
   assign out_of_range = operand[31] || (operand[30:17] != 14'd0) ||
                         (operand[16:0] >= length_ff);
   assign count_inc    = count_ff + 17'd1;
   assign index_in     = base_ff + count_ff[15:0];

   always_comb begin
      operand_in = operand;
      status_in  = STATUS_OK;
      if (req_tdata[7] || accum_in[32]) begin
         status_in  = STATUS_OVERFLOW;
         operand_in = '0;
      end else if (is_code_target(opcode_ff)) begin
         if (out_of_range) begin
            status_in = STATUS_RANGE;
         end else begin
            operand_in = operand + {16'b0, base_ff};
         end
      end
   end

   assign last_in = (status_in == STATUS_OK) && (count_inc == length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         length_ff     <= 17'd1;
         in_operand_ff <= 1'b0;
         opcode_ff     <= '0;
         accum_ff      <= '0;
         shift_ff      <= '0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
      end else if (cfg_hit) begin
         if (csr_index == REG_FUNCTION_BASE) begin
            base_ff <= csr_wdata[15:0];
         end else begin
            length_ff <= length_in;
         end
         in_operand_ff <= 1'b0;
         opcode_ff     <= '0;
         accum_ff      <= '0;
         shift_ff      <= '0;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
      end else if (accept && active) begin
         if (!in_operand_ff) begin
            opcode_ff     <= req_tdata;
            in_operand_ff <= 1'b1;
            accum_ff      <= '0;
            shift_ff      <= '0;
         end else if (done) begin
            in_operand_ff <= 1'b0;
            accum_ff      <= '0;
            shift_ff      <= '0;
            if (status_in != STATUS_OK) begin
               halted_ff <= 1'b1;
            end else begin
               count_ff <= count_inc;
            end
         end else begin
            accum_ff <= accum_in;
            shift_ff <= shift_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_opcode_ff  <= opcode_ff;
         rsp_operand_ff <= operand_in;
         rsp_index_ff   <= index_in;
         rsp_last_ff    <= last_in;
         rsp_status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_operand_ff, rsp_opcode_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hdl/bid_checker.sv =====
// Port-level checker for the bytecode instruction decoder, bound to the core.
// Depends on bid_pkg and bytecode_instruction_decoder_core_assert.svh.
`default_nettype none

`include "bytecode_instruction_decoder_core_assert.svh"

module bid_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [bid_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input wire                                rsp_tlast,
   input wire [bid_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import bid_pkg::*;

   `BID_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response word changed")
   `BID_ASSERT_IMPL(a_ready_when_empty, !rsp_tvalid, req_tready, "input stalled with empty output register")
   `BID_ASSERT_IMPL(a_err_not_last, rsp_tvalid && rsp_tuser != STATUS_OK, !rsp_tlast, "error word flagged as last")
   `BID_ASSERT_IMPL(a_ovf_zero, rsp_tvalid && rsp_tuser == STATUS_OVERFLOW, rsp_tdata[39:8] == 32'd0, "overflow word with nonzero operand")
   `BID_ASSERT_IMPL(a_stall_backpressure, rsp_tvalid && !rsp_tready, !req_tready, "input taken while result word stalled")

endmodule

bind bytecode_instruction_decoder_core bid_checker u_bid_checker (.*);

`default_nettype wire
